// File: rtl/core/aes128_key_expansion_unit_macros.svh
// Assertion macros shared by the AES-128 key expansion RTL.
`ifndef AES128_KEY_EXPANSION_UNIT_MACROS_SVH
`define AES128_KEY_EXPANSION_UNIT_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define AKX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define AKX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/akx_pkg.sv
// Types, constants and round functions of the AES-128 key expansion unit.
package akx_pkg;

  localparam int NUM_ROUNDS = 10;
  localparam int ROUND_W    = 4;

  typedef struct packed {
    logic [63:0] key_high;
    logic [63:0] key_low;
  } akx_in_t;

  typedef struct packed {
    logic [ROUND_W-1:0] round_number;
    logic [63:0]        round_key_high;
    logic [63:0]        round_key_low;
    logic               last_key;
  } akx_out_t;

  // What one cell hands to the next: a token flag and the round key it holds.
  typedef struct packed {
    logic         valid;
    logic [127:0] key;
  } akx_tok_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] RCON [0:NUM_ROUNDS-1] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [31:0] sub_word(logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One step of the key schedule: previous round key in, next round key out.
  function automatic logic [127:0] next_round_key(logic [127:0] k, logic [7:0] rc);
    logic [31:0] t;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [31:0] w3;
    t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h000000};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// File: rtl/core/akx_round_cell.sv
// One cell of the key schedule chain: derives and holds one round key.
module akx_round_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  akx_pkg::akx_tok_t prev,
  input  logic [7:0]       rcon,
  output akx_pkg::akx_tok_t cur
);
  import akx_pkg::*;

  logic         valid;
  logic [127:0] key;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= prev.valid;
    end
  end

  // The key register follows its neighbour whether or not a token is present.
  always_ff @(posedge clk) begin
    if (advance) begin
      key <= next_round_key(prev.key, rcon);
    end
  end

  assign cur = '{valid: valid, key: key};

endmodule

// File: rtl/core/aes128_key_expansion_unit.sv
// AES-128 key expansion unit: one cipher key in, eleven round keys out.
// Round key r of a key passes the entry register, cells 1 to r, then the output register.
// Throughput: one round key per cycle while rkey_stall is low, so one key per eleven
// round keys; the single result port that takes one round key per transaction sets that rate.
// A new key is taken in the cycle its predecessor's last round is moved out.
// Reset clears the token bits of the cell chain and the output valid flag.
`include "aes128_key_expansion_unit_macros.svh"

module aes128_key_expansion_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_stall,
  input  akx_pkg::akx_in_t  key_data,
  output logic             rkey_valid,
  input  logic             rkey_stall,
  output akx_pkg::akx_out_t rkey_data
);
  import akx_pkg::*;

  akx_tok_t                tok [0:NUM_ROUNDS];
  logic     [NUM_ROUNDS:0] tok_valid;
  logic                    advance;
  logic                    key_accept;
  logic                    entry_valid;
  logic     [127:0]        entry_key;
  logic     [127:0]        sel_key;
  logic     [ROUND_W-1:0]  sel_round;
  akx_out_t                rkey_next;

  // The output register moves on when it is empty or its content is taken.
  assign advance    = !rkey_valid || !rkey_stall;
  // The last cell's token leaves at this edge, so a new key may enter behind it.
  assign key_stall  = !(advance && !(|tok_valid[NUM_ROUNDS-1:0]));
  assign key_accept = key_valid && !key_stall;

  // Entry cell holds round 0, the cipher key itself.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (advance) begin
      entry_valid <= key_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_key <= {key_data.key_high, key_data.key_low};
    end
  end

  assign tok[0] = '{valid: entry_valid, key: entry_key};

  for (genvar i = 1; i <= NUM_ROUNDS; i++) begin : g_cell
    akx_round_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .prev    (tok[i-1]),
      .rcon    (RCON[i-1]),
      .cur     (tok[i])
    );
  end

  // At most one cell carries a token, so the selection is an AND-OR.
  always_comb begin
    sel_key   = '0;
    sel_round = '0;
    for (int i = 0; i <= NUM_ROUNDS; i++) begin
      tok_valid[i] = tok[i].valid;
      if (tok[i].valid) begin
        sel_key   = sel_key | tok[i].key;
        sel_round = sel_round | ROUND_W'(i);
      end
    end
  end

  always_comb begin
    rkey_next.round_number   = sel_round;
    rkey_next.round_key_high = sel_key[127:64];
    rkey_next.round_key_low  = sel_key[63:0];
    rkey_next.last_key       = tok_valid[NUM_ROUNDS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rkey_valid <= 1'b0;
    end else if (advance) begin
      rkey_valid <= |tok_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rkey_data <= rkey_next;
    end
  end

  `AKX_ASSERT_SAME(a_single_token, 1'b1, $onehot0(tok_valid), "more than one token in the chain")
  `AKX_ASSERT_NEXT(a_rounds_follow, rkey_valid && !rkey_stall && !rkey_data.last_key, rkey_valid, "gap inside a key's rounds")
  `AKX_ASSERT_NEXT(a_round_count, rkey_valid && !rkey_stall && !rkey_data.last_key, rkey_data.round_number == $past(rkey_data.round_number) + 4'd1, "round number did not step by one")
  `AKX_ASSERT_NEXT(a_restart_at_zero, rkey_valid && !rkey_stall && rkey_data.last_key, !rkey_valid || rkey_data.round_number == '0, "new key did not start at round 0")

endmodule

// File: verif/tb.sv
// Self-checking testbench for the AES-128 key expansion unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import akx_pkg::*;

  localparam int DIRECTED_KEYS = 9;
  localparam int RANDOM_KEYS   = 200;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 24;

  class round_key_scoreboard;
    localparam int LAST_ROUND = 10;

    logic [7:0] sbox_tab [256];
    akx_out_t   round_keys_due [$];
    int         n_keys;
    int         n_checked;
    int         n_errors;

    // The S-box is derived from the field inverse and the affine map rather
    // than typed in, so that a wrong table entry in the design cannot hide.
    function new();
      logic [7:0] inv;
      n_keys    = 0;
      n_checked = 0;
      n_errors  = 0;
      for (int x = 0; x < 256; x++) begin
        inv = 8'h00;
        for (int y = 1; y < 256; y++) begin
          if (gf_mul(8'(x), 8'(y)) == 8'h01) inv = 8'(y);
        end
        sbox_tab[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^
                      rotl8(inv, 4) ^ 8'h63;
      end
    endfunction

    function logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[0]) p ^= a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        b = b >> 1;
      end
      return p;
    endfunction

    function logic [7:0] rotl8(logic [7:0] v, int n);
      return (v << n) | (v >> (8 - n));
    endfunction

    function int outstanding();
      return round_keys_due.size();
    endfunction

    // Works out the eleven round keys of an accepted cipher key.
    function void note_key(akx_in_t k);
      logic [31:0] w [4];
      logic [31:0] t;
      logic [7:0]  rc;
      akx_out_t    e;
      w[0] = k.key_high[63:32];
      w[1] = k.key_high[31:0];
      w[2] = k.key_low[63:32];
      w[3] = k.key_low[31:0];
      rc   = 8'h01;
      n_keys++;
      for (int r = 0; r <= LAST_ROUND; r++) begin
        if (r > 0) begin
          // Last word rotated left by one byte, then substituted byte by byte.
          t = {sbox_tab[w[3][23:16]], sbox_tab[w[3][15:8]],
               sbox_tab[w[3][7:0]], sbox_tab[w[3][31:24]]} ^ {rc, 24'h000000};
          w[0] ^= t;
          w[1] ^= w[0];
          w[2] ^= w[1];
          w[3] ^= w[2];
          rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end
        e.round_number   = 4'(r);
        e.round_key_high = {w[0], w[1]};
        e.round_key_low  = {w[2], w[3]};
        e.last_key       = (r == LAST_ROUND);
        round_keys_due.push_back(e);
      end
    endfunction

    task report_mismatch(string what);
      n_errors++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_round_key(akx_out_t got);
      akx_out_t want;
      if (round_keys_due.size() == 0) begin
        report_mismatch($sformatf("unexpected round key, round %0d", got.round_number));
        return;
      end
      want = round_keys_due.pop_front();
      n_checked++;
      if (got.round_number !== want.round_number)
        report_mismatch($sformatf("round_number %0d, wanted %0d",
                                  got.round_number, want.round_number));
      if (got.round_key_high !== want.round_key_high)
        report_mismatch($sformatf("round %0d round_key_high %h, wanted %h",
                                  want.round_number, got.round_key_high,
                                  want.round_key_high));
      if (got.round_key_low !== want.round_key_low)
        report_mismatch($sformatf("round %0d round_key_low %h, wanted %h",
                                  want.round_number, got.round_key_low,
                                  want.round_key_low));
      if (got.last_key !== want.last_key)
        report_mismatch($sformatf("round %0d last_key %b, wanted %b",
                                  want.round_number, got.last_key, want.last_key));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     key_valid = 1'b0;
  logic     key_stall;
  akx_in_t  key_data = '0;
  logic     rkey_valid;
  logic     rkey_stall = 1'b0;
  akx_out_t rkey_data;

  int send_idle_pct  = 26;
  int recv_stall_pct = 77;
  int n_sent = 0;
  int quiet_cycles = 0;

  round_key_scoreboard sb = new();

  aes128_key_expansion_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .key_valid  (key_valid),
    .key_stall  (key_stall),
    .key_data   (key_data),
    .rkey_valid (rkey_valid),
    .rkey_stall (rkey_stall),
    .rkey_data  (rkey_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one key, idling beforehand at the current rate, and returns at the
  // edge at which the transaction completes.
  task automatic send_key(input akx_in_t k);
    if (n_sent < 70) begin
      send_idle_pct  = 26;
      recv_stall_pct = 77;
    end else if (n_sent < 140) begin
      send_idle_pct  = 77;
      recv_stall_pct = 26;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      key_valid <= 1'b0;
      @(posedge clk);
    end
    key_valid <= 1'b1;
    key_data  <= k;
    do @(posedge clk); while (key_stall);
    sb.note_key(k);
    n_sent++;
  endtask

  always @(posedge clk) begin
    rkey_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rkey_valid && !rkey_stall) sb.check_round_key(rkey_data);
  end

  always @(posedge clk) begin
    if (rst || (key_valid && !key_stall) || (rkey_valid && !rkey_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d round keys outstanding",
               QUIET_LIMIT, sb.outstanding());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [127:0] directed [DIRECTED_KEYS];
    logic [127:0] k;
    logic [7:0]   b;
    directed[0] = '0;
    directed[1] = '1;
    directed[2] = 128'h2b7e1516_28aed2a6_abf71588_09cf4f3c;
    directed[3] = 128'h00010203_04050607_08090a0b_0c0d0e0f;
    directed[4] = {4{32'haaaaaaaa}};
    directed[5] = {4{32'h55555555}};
    directed[6] = {1'b1, 127'b0};
    directed[7] = 128'h1;
    directed[8] = {96'hffffffff_ffffffff_ffffffff, 32'h00000000};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_KEYS; i++) send_key(directed[i]);

    for (int i = 0; i < RANDOM_KEYS; i++) begin
      case ($urandom_range(9))
        0: k = 128'h1 << $urandom_range(127);
        1: begin
          b = 8'($urandom_range(255));
          k = {16{b}};
        end
        2: k = ~(128'h1 << $urandom_range(127));
        default: k = {$urandom, $urandom, $urandom, $urandom};
      endcase
      send_key(k);
    end
    key_valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Expanded %0d keys (directed edge patterns, then random under three",
             sb.n_keys);
    $display("idling mixes); %0d round keys checked, %0d mismatches",
             sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: aes128_key_expansion_unit.f
+incdir+rtl/core
rtl/core/akx_pkg.sv
rtl/core/akx_round_cell.sv
rtl/core/aes128_key_expansion_unit.sv
verif/tb.sv
